// ----- design/ows_pkg.sv -----
// ----------------------------------------------------------------------------
// ows_pkg
// Types and constants shared by the 1-Wire ROM search sequencer.
// ----------------------------------------------------------------------------
package ows_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_FIRST   = 3'd0;
  localparam logic [2:0] OP_NEXT    = 3'd1;
  localparam logic [2:0] OP_TARGET  = 3'd2;
  localparam logic [2:0] OP_SKIP    = 3'd3;
  localparam logic [2:0] OP_TRIPLET = 3'd4;

  typedef enum logic [1:0] {
    KIND_TRIPLET_REQ = 2'd0,
    KIND_FINISHED    = 2'd1,
    KIND_SETUP_ACK   = 2'd2,
    KIND_IGNORED     = 2'd3
  } reply_kind_t;

  localparam logic [7:0] CMD_NORMAL_SEARCH = 8'hF0;
  localparam logic [7:0] CMD_ALARM_SEARCH  = 8'hEC;
  localparam logic [7:0] CRC_POLY          = 8'h8C;
  localparam logic [6:0] ROM_BITS          = 7'd64;
  localparam logic [6:0] FAMILY_LIMIT      = 7'd9;

  typedef struct packed {
    logic [2:0] operation;
    logic       presence;
    logic [7:0] family_byte;
    logic       id_bit;
    logic       comp_bit;
    logic       direction_taken;
  } in_item_t;

  typedef struct packed {
    reply_kind_t reply_kind;
    logic        send_command;
    logic [7:0]  command_byte;
    logic        direction;
    logic [6:0]  bit_position;
    logic        found;
    logic        last_device;
    logic [63:0] rom_code;
  } out_item_t;

endpackage

// ----- design/ows_engine.sv -----
// ----------------------------------------------------------------------------
// ows_engine
// Search state registers and the combinational step that updates them and
// forms the reply for one item.
// ----------------------------------------------------------------------------
module ows_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ows_pkg::in_item_t  item,
  input  logic               alarm_search,
  output ows_pkg::out_item_t result
);

  logic [63:0] rom_r,       rom_nxt;
  logic [6:0]  last_disc_r, last_disc_nxt;
  logic [3:0]  last_fam_r,  last_fam_nxt;
  logic        last_dev_r,  last_dev_nxt;
  logic [6:0]  cur_bit_r,   cur_bit_nxt;
  logic [6:0]  last_zero_r, last_zero_nxt;
  logic [7:0]  crc_r,       crc_nxt;
  logic        active_r,    active_nxt;

  logic [7:0]  crc_shift;
  logic        crc_fb;
  logic [6:0]  bit_inc;

  // preferred direction for ROM bit b (1-based)
  function automatic logic pref_dir(input logic [6:0] b, input logic [6:0] ld,
                                    input logic [63:0] rom);
    logic [6:0] idx;
    idx = b - 7'd1;
    if (b < ld) begin
      return rom[idx[5:0]];
    end
    return (b == ld);
  endfunction

  always_comb begin
    rom_nxt       = rom_r;
    last_disc_nxt = last_disc_r;
    last_fam_nxt  = last_fam_r;
    last_dev_nxt  = last_dev_r;
    cur_bit_nxt   = cur_bit_r;
    last_zero_nxt = last_zero_r;
    crc_nxt       = crc_r;
    active_nxt    = active_r;

    result              = '0;
    result.reply_kind   = ows_pkg::KIND_IGNORED;

    crc_fb    = crc_r[0] ^ item.direction_taken;
    crc_shift = {1'b0, crc_r[7:1]} ^ (crc_fb ? ows_pkg::CRC_POLY : 8'h00);
    bit_inc   = cur_bit_r + 7'd1;

    case (item.operation)
      ows_pkg::OP_FIRST, ows_pkg::OP_NEXT: begin
        if (item.operation == ows_pkg::OP_FIRST) begin
          last_disc_nxt = '0;
          last_fam_nxt  = '0;
          last_dev_nxt  = 1'b0;
        end
        if (last_dev_nxt || !item.presence) begin
          last_disc_nxt     = '0;
          last_fam_nxt      = '0;
          last_dev_nxt      = 1'b0;
          active_nxt        = 1'b0;
          result.reply_kind = ows_pkg::KIND_FINISHED;
        end else begin
          active_nxt          = 1'b1;
          cur_bit_nxt         = 7'd1;
          last_zero_nxt       = '0;
          crc_nxt             = '0;
          result.reply_kind   = ows_pkg::KIND_TRIPLET_REQ;
          result.send_command = 1'b1;
          result.command_byte = alarm_search ? ows_pkg::CMD_ALARM_SEARCH
                                             : ows_pkg::CMD_NORMAL_SEARCH;
          result.direction    = pref_dir(7'd1, last_disc_nxt, rom_r);
          result.bit_position = 7'd1;
        end
      end
      ows_pkg::OP_TARGET: begin
        active_nxt        = 1'b0;
        rom_nxt           = {56'd0, item.family_byte};
        last_disc_nxt     = ows_pkg::ROM_BITS;
        last_fam_nxt      = '0;
        last_dev_nxt      = 1'b0;
        result.reply_kind = ows_pkg::KIND_SETUP_ACK;
      end
      ows_pkg::OP_SKIP: begin
        active_nxt    = 1'b0;
        last_disc_nxt = {3'd0, last_fam_r};
        last_fam_nxt  = '0;
        if (last_fam_r == 4'd0) begin
          last_dev_nxt = 1'b0;
        end
        result.reply_kind = ows_pkg::KIND_SETUP_ACK;
      end
      ows_pkg::OP_TRIPLET: begin
        if (active_r) begin
          if (item.id_bit && item.comp_bit) begin
            last_disc_nxt     = '0;
            last_fam_nxt      = '0;
            last_dev_nxt      = 1'b0;
            active_nxt        = 1'b0;
            result.reply_kind = ows_pkg::KIND_FINISHED;
          end else begin
            if (!item.id_bit && !item.comp_bit && !item.direction_taken) begin
              last_zero_nxt = cur_bit_r;
              if (cur_bit_r < ows_pkg::FAMILY_LIMIT) begin
                last_fam_nxt = cur_bit_r[3:0];
              end
            end
            rom_nxt[cur_bit_r[5:0] - 6'd1] = item.direction_taken;
            crc_nxt = crc_shift;
            if (cur_bit_r >= ows_pkg::ROM_BITS) begin
              result.reply_kind = ows_pkg::KIND_FINISHED;
              active_nxt        = 1'b0;
              if (crc_shift != 8'd0 || rom_nxt[7:0] == 8'd0) begin
                last_disc_nxt = '0;
                last_fam_nxt  = '0;
                last_dev_nxt  = 1'b0;
              end else begin
                last_disc_nxt = last_zero_nxt;
                if (last_zero_nxt == 7'd0) begin
                  last_dev_nxt = 1'b1;
                end
                result.found       = 1'b1;
                result.last_device = last_dev_nxt;
              end
            end else begin
              cur_bit_nxt         = bit_inc;
              result.reply_kind   = ows_pkg::KIND_TRIPLET_REQ;
              result.direction    = pref_dir(bit_inc, last_disc_r, rom_nxt);
              result.bit_position = bit_inc;
            end
          end
        end
      end
      default: begin
        result.reply_kind = ows_pkg::KIND_IGNORED;
      end
    endcase

    result.rom_code = rom_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r       <= '0;
      last_disc_r <= '0;
      last_fam_r  <= '0;
      last_dev_r  <= 1'b0;
      cur_bit_r   <= 7'd1;
      last_zero_r <= '0;
      crc_r       <= '0;
      active_r    <= 1'b0;
    end else if (fire) begin
      rom_r       <= rom_nxt;
      last_disc_r <= last_disc_nxt;
      last_fam_r  <= last_fam_nxt;
      last_dev_r  <= last_dev_nxt;
      cur_bit_r   <= cur_bit_nxt;
      last_zero_r <= last_zero_nxt;
      crc_r       <= crc_nxt;
      active_r    <= active_nxt;
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_bit_r != 7'd0 && cur_bit_r <= ows_pkg::ROM_BITS))
    else $error("current bit out of range during search");

  a_fam_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_fam_r < ows_pkg::FAMILY_LIMIT[3:0])
    else $error("family discrepancy beyond family byte");

  a_found_rom: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.found) |=> (rom_r[7:0] != 8'd0 && crc_r == 8'd0 && !active_r))
    else $error("device reported found with bad ROM state");

endmodule

// ----- design/one_wire_rom_search.sv -----
// ----------------------------------------------------------------------------
// one_wire_rom_search
// 1-Wire ROM search sequencer: input register, search step, result register.
// ----------------------------------------------------------------------------
// Throughput: 1 item per cycle when out_stall is low; the state updates in
//   one step, so each item sees the state left by the one before it.
// Reset (rst_n low, synchronous): pipeline empty, search state cleared,
//   current bit 1, normal search command selected. No clearing pass.
module one_wire_rom_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ows_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ows_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic               in_vld_r;
  ows_pkg::in_item_t  in_item_r;
  logic               out_vld_r;
  ows_pkg::out_item_t out_item_r;
  ows_pkg::out_item_t step_result;
  logic               alarm_r;
  logic               fire;

  // step the engine when the result register is free or draining
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign cfg_ready = 1'b1;

  ows_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (in_item_r),
    .alarm_search (alarm_r),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      alarm_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        alarm_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("stepped transaction did not reach result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !fire)
    else $error("stalled result overwritten");

endmodule
